[rtl/core/per_user_memory_limit_checker_defines.svh]
// Assertion macros for the per-user memory limit checker.
// Included by the top level; no other dependencies.
`ifndef PER_USER_MEMORY_LIMIT_CHECKER_DEFINES_SVH
`define PER_USER_MEMORY_LIMIT_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
`define PUMLC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pumlc assertion failed");
`define PUMLC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pumlc assertion failed");
`else
`define PUMLC_ASSERT_IMP(lbl, ante, cons)
`define PUMLC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/pumlc_pkg.sv]
// Shared types and constants of the per-user memory limit checker.
// No dependencies.
package pumlc_pkg;
    localparam int LIM_N      = 16;
    localparam int LIM_IW     = 4;
    localparam int LIM_CW     = 5;
    localparam int ACC_N      = 32;
    localparam int ACC_IW     = 5;
    localparam int ACC_CW     = 6;
    localparam int PAGE_SHIFT = 12;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_CLR   = 2'd1;
    localparam logic [1:0] OP_ACCT  = 2'd2;
    localparam logic [1:0] OP_CHECK = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LIM_FULL = 2'd1;
    localparam logic [1:0] ST_ACC_FULL = 2'd2;
    localparam logic [1:0] ST_NO_USERS = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] user_id;
        logic [63:0] limit_value;
        logic [35:0] rss_pages;
        logic [21:0] task_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_user;
        logic [63:0] total_bytes;
        logic [63:0] user_limit;
        logic [63:0] largest_bytes;
        logic [21:0] largest_task;
        logic        kill;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic valid;
        logic found;
        logic added;
    } tok_t;
endpackage

[rtl/core/per_user_memory_limit_checker.sv]
// Top level of the per-user memory limit checker: sequencer, cell chains, output register.
// Depends on pumlc_pkg, pumlc_lim_cell, pumlc_acct_cell and the defines header.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (pumlc_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (pumlc_pkg::rsp_t)
//
// Set limit walks a token down the 16 limit cells.
// Account task walks the 32 accounting cells.
// Clear goes straight to the emit state; check steps through the read, match and select states for each user.
// Reset clears the counts and control; table entries hold no reset value.
// A stalled result holds in the output register; the next request is taken meanwhile.
`include "per_user_memory_limit_checker_defines.svh"
module per_user_memory_limit_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  pumlc_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output pumlc_pkg::rsp_t rsp
);
    import pumlc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_CRD  = 6'b000100,
        S_CMAT = 6'b001000,
        S_CSEL = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t            st_reg;
    req_t              req_reg;
    logic              start_reg;
    logic [LIM_CW-1:0] lcnt_reg;
    logic [ACC_CW-1:0] acnt_reg;
    logic [ACC_IW-1:0] idx_reg;
    logic [31:0]       q_user_reg;
    logic [63:0]       q_total_reg;
    logic [63:0]       q_big_reg;
    logic [21:0]       q_task_reg;
    rsp_t              pend_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    tok_t        ltok [LIM_N+1];
    tok_t        atok [ACC_N+1];
    logic        l_match [LIM_N];
    logic [63:0] l_val [LIM_N];
    logic [31:0] a_id [ACC_N];
    logic [63:0] a_total [ACC_N];
    logic [63:0] a_big [ACC_N];
    logic [21:0] a_task [ACC_N];

    logic [63:0] cost;
    logic        accept;
    logic        emit;
    logic        is_last;
    logic [63:0] sel_lim;
    tok_t        tail;
    rsp_t        idle_rsp;
    rsp_t        walk_rsp;
    rsp_t        chk_rsp;

    assign cost    = {16'd0, req_reg.rss_pages, {PAGE_SHIFT{1'b0}}};
    assign accept  = req_valid && !req_stall;
    assign emit    = (st_reg == S_EMIT) && (!rsp_valid_reg || !rsp_stall);
    assign is_last = ({1'b0, idx_reg} + ACC_CW'(1)) == acnt_reg;
    assign tail    = (req_reg.op == OP_ACCT) ? atok[ACC_N] : ltok[LIM_N];

    always_comb
    begin
        ltok[0].valid = start_reg && (req_reg.op == OP_SET);
        ltok[0].found = 1'b0;
        ltok[0].added = 1'b0;
        atok[0].valid = start_reg && (req_reg.op == OP_ACCT);
        atok[0].found = 1'b0;
        atok[0].added = 1'b0;
    end

    for (genvar i = 0; i < LIM_N; i++)
    begin : g_lim
        pumlc_lim_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (LIM_IW'(i)),
            .count   (lcnt_reg),
            .user    (req_reg.user_id),
            .value   (req_reg.limit_value),
            .qry     (q_user_reg),
            .tok_in  (ltok[i]),
            .tok_out (ltok[i+1]),
            .match   (l_match[i]),
            .lim     (l_val[i])
        );
    end

    for (genvar i = 0; i < ACC_N; i++)
    begin : g_acct
        pumlc_acct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (ACC_IW'(i)),
            .count    (acnt_reg),
            .user     (req_reg.user_id),
            .cost     (cost),
            .task_id  (req_reg.task_id),
            .tok_in   (atok[i]),
            .tok_out  (atok[i+1]),
            .id       (a_id[i]),
            .total    (a_total[i]),
            .largest  (a_big[i]),
            .big_task (a_task[i])
        );
    end

    // first matching limit entry wins
    always_comb
    begin
        sel_lim = '0;
        for (int k = LIM_N - 1; k >= 0; k--)
        begin
            if (l_match[k])
                sel_lim = l_val[k];
        end
    end

    always_comb
    begin
        idle_rsp      = '0;
        idle_rsp.last = 1'b1;
        if (req.op == OP_CHECK && acnt_reg == '0)
            idle_rsp.status = ST_NO_USERS;
        walk_rsp      = '0;
        walk_rsp.last = 1'b1;
        if (!tail.found)
            walk_rsp.status = (req_reg.op == OP_ACCT) ? ST_ACC_FULL : ST_LIM_FULL;
        chk_rsp               = '0;
        chk_rsp.status        = ST_OK;
        chk_rsp.out_user      = q_user_reg;
        chk_rsp.total_bytes   = q_total_reg;
        chk_rsp.user_limit    = sel_lim;
        chk_rsp.largest_bytes = q_big_reg;
        chk_rsp.largest_task  = q_task_reg;
        chk_rsp.kill          = (sel_lim != '0) && (q_total_reg > sel_lim);
        chk_rsp.last          = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            start_reg     <= 1'b0;
            lcnt_reg      <= '0;
            acnt_reg      <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept && ((req.op == OP_SET) || (req.op == OP_ACCT));
            if (emit)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.op)
                            OP_SET, OP_ACCT: st_reg <= S_WALK;
                            OP_CLR:
                            begin
                                acnt_reg <= '0;
                                st_reg   <= S_EMIT;
                            end
                            default:
                            begin
                                idx_reg <= '0;
                                st_reg  <= (acnt_reg == '0) ? S_EMIT : S_CRD;
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    if (tail.valid)
                    begin
                        if (req_reg.op == OP_ACCT)
                            acnt_reg <= acnt_reg + ACC_CW'(tail.added);
                        else
                            lcnt_reg <= lcnt_reg + LIM_CW'(tail.added);
                        st_reg <= S_EMIT;
                    end
                end
                S_CRD:  st_reg <= S_CMAT;
                S_CMAT: st_reg <= S_CSEL;
                S_CSEL: st_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (emit)
                    begin
                        if (pend_reg.last)
                            st_reg <= S_IDLE;
                        else
                        begin
                            idx_reg <= idx_reg + ACC_IW'(1);
                            st_reg  <= S_CRD;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
        if (emit)
            rsp_reg <= pend_reg;
        case (st_reg)
            S_IDLE: pend_reg <= idle_rsp;
            S_WALK: pend_reg <= walk_rsp;
            S_CRD:
            begin
                q_user_reg  <= a_id[idx_reg];
                q_total_reg <= a_total[idx_reg];
                q_big_reg   <= a_big[idx_reg];
                q_task_reg  <= a_task[idx_reg];
            end
            S_CSEL: pend_reg <= chk_rsp;
            default: ;
        endcase
    end

    assign req_stall = (st_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PUMLC_ASSERT_IMP(a_lcnt_max, 1'b1, lcnt_reg <= LIM_CW'(LIM_N))
    `PUMLC_ASSERT_IMP(a_acnt_max, 1'b1, acnt_reg <= ACC_CW'(ACC_N))
    `PUMLC_ASSERT_IMP(a_nouser_last, rsp_valid_reg && rsp_reg.status == ST_NO_USERS, rsp_reg.last)
    `PUMLC_ASSERT_NXT(a_emit_valid, emit, rsp_valid_reg)
endmodule

[rtl/core/pumlc_lim_cell.sv]
// One entry of the limit table chain; passes the search token to its neighbor.
// Depends on pumlc_pkg.
module pumlc_lim_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pumlc_pkg::LIM_IW-1:0] idx,
    input  logic [pumlc_pkg::LIM_CW-1:0] count,
    input  logic [31:0]                 user,
    input  logic [63:0]                 value,
    input  logic [31:0]                 qry,
    input  pumlc_pkg::tok_t             tok_in,
    output pumlc_pkg::tok_t             tok_out,
    output logic                        match,
    output logic [63:0]                 lim
);
    import pumlc_pkg::*;

    logic [31:0] id_reg;
    logic [63:0] val_reg;
    logic        match_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        occ;
    logic        hit;
    logic        app;

    assign occ = {1'b0, idx} < count;
    assign hit = tok_in.valid && !tok_in.found && occ && (id_reg == user);
    assign app = tok_in.valid && !tok_in.found && ({1'b0, idx} == count);

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found | hit | app;
        tok_next.added = tok_in.added | app;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            tok_reg   <= tok_next;
            match_reg <= occ && (id_reg == qry);
        end
    end

    always_ff @(posedge clk)
    begin
        if (app)
        begin
            id_reg  <= user;
            val_reg <= value;
        end
        else if (hit)
        begin
            val_reg <= value;
        end
    end

    assign tok_out = tok_reg;
    assign match   = match_reg;
    assign lim     = val_reg;
endmodule

[rtl/core/pumlc_acct_cell.sv]
// One entry of the accounting table chain; passes the search token onward.
// Depends on pumlc_pkg.
module pumlc_acct_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pumlc_pkg::ACC_IW-1:0] idx,
    input  logic [pumlc_pkg::ACC_CW-1:0] count,
    input  logic [31:0]                 user,
    input  logic [63:0]                 cost,
    input  logic [21:0]                 task_id,
    input  pumlc_pkg::tok_t             tok_in,
    output pumlc_pkg::tok_t             tok_out,
    output logic [31:0]                 id,
    output logic [63:0]                 total,
    output logic [63:0]                 largest,
    output logic [21:0]                 big_task
);
    import pumlc_pkg::*;

    logic [31:0] id_reg;
    logic [63:0] total_reg;
    logic [63:0] big_reg;
    logic [21:0] task_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        occ;
    logic        hit;
    logic        app;
    logic [64:0] sum;
    logic [63:0] sat;

    assign occ = {1'b0, idx} < count;
    assign hit = tok_in.valid && !tok_in.found && occ && (id_reg == user);
    assign app = tok_in.valid && !tok_in.found && ({1'b0, idx} == count);
    assign sum = {1'b0, total_reg} + {1'b0, cost};
    assign sat = sum[64] ? '1 : sum[63:0];

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found | hit | app;
        tok_next.added = tok_in.added | app;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    always_ff @(posedge clk)
    begin
        if (app)
        begin
            id_reg    <= user;
            total_reg <= cost;
            big_reg   <= cost;
            task_reg  <= task_id;
        end
        else if (hit)
        begin
            total_reg <= sat;
            if (cost > big_reg)
            begin
                big_reg  <= cost;
                task_reg <= task_id;
            end
        end
    end

    assign tok_out  = tok_reg;
    assign id       = id_reg;
    assign total    = total_reg;
    assign largest  = big_reg;
    assign big_task = task_reg;
endmodule

[test/per_user_memory_limit_checker_test.sv]
// Self-checking testbench of the per-user memory limit checker.
// Predicts every result of each request transfer and compares it field by field.
// Depends on pumlc_pkg and per_user_memory_limit_checker.
`timescale 1ns / 1ps
module per_user_memory_limit_checker_test;
    import pumlc_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   error_count;
    int   rsp_count;
    int   kill_count;
    int   req_count;

    logic [31:0] lim_user[LIM_N];
    logic [63:0] lim_value[LIM_N];
    int          lim_count;
    logic [31:0] acc_user[ACC_N];
    logic [63:0] acc_total[ACC_N];
    logic [63:0] acc_big[ACC_N];
    logic [21:0] acc_big_task[ACC_N];
    int          acc_count;

    logic [31:0] user_pool[40];

    per_user_memory_limit_checker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic rsp_t plain_rsp(logic [1:0] status);
        rsp_t r;
        r = '0;
        r.status = status;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [63:0] limit_of(logic [31:0] user);
        for (int i = 0; i < lim_count; i++)
            if (lim_user[i] == user)
                return lim_value[i];
        return 64'd0;
    endfunction

    task automatic predict_results(req_t t);
        logic [63:0] cost;
        logic [64:0] sum;
        logic [63:0] lim;
        rsp_t r;
        int hit;
        hit = -1;
        case (t.op)
            OP_SET:
            begin
                for (int i = 0; i < lim_count; i++)
                    if (hit < 0 && lim_user[i] == t.user_id)
                        hit = i;
                if (hit >= 0)
                begin
                    lim_value[hit] = t.limit_value;
                    expected_rsps.push_back(plain_rsp(ST_OK));
                end
                else if (lim_count >= LIM_N)
                    expected_rsps.push_back(plain_rsp(ST_LIM_FULL));
                else
                begin
                    lim_user[lim_count] = t.user_id;
                    lim_value[lim_count] = t.limit_value;
                    lim_count++;
                    expected_rsps.push_back(plain_rsp(ST_OK));
                end
            end
            OP_CLR:
            begin
                acc_count = 0;
                expected_rsps.push_back(plain_rsp(ST_OK));
            end
            OP_ACCT:
            begin
                cost = {16'd0, t.rss_pages, 12'd0};
                for (int i = 0; i < acc_count; i++)
                    if (hit < 0 && acc_user[i] == t.user_id)
                        hit = i;
                if (hit >= 0)
                begin
                    sum = {1'b0, acc_total[hit]} + {1'b0, cost};
                    acc_total[hit] = sum[64] ? {64{1'b1}} : sum[63:0];
                    if (cost > acc_big[hit])
                    begin
                        acc_big[hit] = cost;
                        acc_big_task[hit] = t.task_id;
                    end
                    expected_rsps.push_back(plain_rsp(ST_OK));
                end
                else if (acc_count >= ACC_N)
                    expected_rsps.push_back(plain_rsp(ST_ACC_FULL));
                else
                begin
                    acc_user[acc_count] = t.user_id;
                    acc_total[acc_count] = cost;
                    acc_big[acc_count] = cost;
                    acc_big_task[acc_count] = t.task_id;
                    acc_count++;
                    expected_rsps.push_back(plain_rsp(ST_OK));
                end
            end
            default:
            begin
                if (acc_count == 0)
                    expected_rsps.push_back(plain_rsp(ST_NO_USERS));
                for (int i = 0; i < acc_count; i++)
                begin
                    lim = limit_of(acc_user[i]);
                    r = '0;
                    r.status = ST_OK;
                    r.out_user = acc_user[i];
                    r.total_bytes = acc_total[i];
                    r.user_limit = lim;
                    r.largest_bytes = acc_big[i];
                    r.largest_task = acc_big_task[i];
                    r.kill = (lim != 0) && (acc_total[i] > lim);
                    r.last = (i == acc_count - 1);
                    expected_rsps.push_back(r);
                end
            end
        endcase
    endtask

    function automatic req_t make_req(logic [1:0] op, logic [31:0] user,
                                      logic [63:0] lim, logic [35:0] pages,
                                      logic [21:0] task_id);
        req_t t;
        t.op = op;
        t.user_id = user;
        t.limit_value = lim;
        t.rss_pages = pages;
        t.task_id = task_id;
        return t;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [35:0] rand36();
        return 36'({$urandom(), $urandom()});
    endfunction

    function automatic logic [21:0] rand22();
        return 22'($urandom());
    endfunction

    function automatic req_t random_req();
        logic [31:0] user;
        logic [63:0] lim;
        logic [35:0] pages;
        int sel;
        sel = $urandom_range(0, 99);
        user = ($urandom_range(0, 9) == 0) ? $urandom() : user_pool[$urandom_range(0, 39)];
        case ($urandom_range(0, 3))
            0: pages = {4'd0, $urandom()} & 36'hFFFF;
            1: pages = rand36();
            2: pages = {36{1'b1}};
            default: pages = 36'($urandom_range(0, 300));
        endcase
        case ($urandom_range(0, 4))
            0: lim = 64'd0;
            1: lim = rand64();
            2: lim = {64{1'b1}};
            default: lim = {42'd0, 10'($urandom_range(0, 1023)), 12'd0};
        endcase
        if (sel < 22)
            return make_req(OP_SET, user, lim, rand36(), rand22());
        if (sel < 26)
            return make_req(OP_CLR, $urandom(), rand64(), rand36(), rand22());
        if (sel < 84)
            return make_req(OP_ACCT, user, rand64(), pages, rand22());
        return make_req(OP_CHECK, $urandom(), rand64(), rand36(), rand22());
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            req_count <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_results(req);
                req_count <= req_count + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= pending_reqs.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_count <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count <= rsp_count + 1;
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result transfer");
                    error_count++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.kill)
                        kill_count++;
                    if (rsp.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.out_user !== e.out_user)
                    begin
                        $error("out_user exp %0h got %0h", e.out_user, rsp.out_user);
                        error_count++;
                    end
                    if (rsp.total_bytes !== e.total_bytes)
                    begin
                        $error("total_bytes exp %0h got %0h", e.total_bytes, rsp.total_bytes);
                        error_count++;
                    end
                    if (rsp.user_limit !== e.user_limit)
                    begin
                        $error("user_limit exp %0h got %0h", e.user_limit, rsp.user_limit);
                        error_count++;
                    end
                    if (rsp.largest_bytes !== e.largest_bytes)
                    begin
                        $error("largest_bytes exp %0h got %0h", e.largest_bytes,
                               rsp.largest_bytes);
                        error_count++;
                    end
                    if (rsp.largest_task !== e.largest_task)
                    begin
                        $error("largest_task exp %0h got %0h", e.largest_task,
                               rsp.largest_task);
                        error_count++;
                    end
                    if (rsp.kill !== e.kill)
                    begin
                        $error("kill exp %0d got %0d", e.kill, rsp.kill);
                        error_count++;
                    end
                    if (rsp.last !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, rsp.last);
                        error_count++;
                    end
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic run_phase(int n, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < n; i++)
            pending_reqs.push_back(random_req());
        while (pending_reqs.size() > 0 || req_valid)
            @(posedge clk);
    endtask

    initial
    begin
        error_count = 0;
        kill_count = 0;
        lim_count = 0;
        acc_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 40; i++)
            user_pool[i] = (i < 3) ? 32'(i * 32'h7FFF_FFFF) : $urandom();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty check, extremes, full tables, tie on largest
        pending_reqs.push_back(make_req(OP_CHECK, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_SET, 32'hFFFF_FFFF, {64{1'b1}}, 0, 0));
        pending_reqs.push_back(make_req(OP_SET, 0, 64'd4096, {36{1'b1}}, 22'h3FFFFF));
        pending_reqs.push_back(make_req(OP_ACCT, 0, 0, 36'd2, 22'h3FFFFF));
        pending_reqs.push_back(make_req(OP_ACCT, 0, {64{1'b1}}, 36'd2, 22'd5));
        pending_reqs.push_back(make_req(OP_ACCT, 32'hFFFF_FFFF, 0, {36{1'b1}}, 0));
        for (int i = 0; i < 5; i++)
            pending_reqs.push_back(make_req(OP_ACCT, 32'hFFFF_FFFF, 0, {36{1'b1}},
                                            22'(i)));
        pending_reqs.push_back(make_req(OP_ACCT, 32'd7, 0, 0, 22'd1));
        pending_reqs.push_back(make_req(OP_CHECK, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_SET, 0, 64'd0, 0, 0));
        for (int i = 0; i < 16; i++)
            pending_reqs.push_back(make_req(OP_SET, 32'(100 + i), 64'(i), 0, 0));
        for (int i = 0; i < 33; i++)
            pending_reqs.push_back(make_req(OP_ACCT, 32'(200 + i), 0, 36'(i), 22'(i)));
        pending_reqs.push_back(make_req(OP_CHECK, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_CLR, 32'hFFFF_FFFF, {64{1'b1}}, {36{1'b1}},
                                        22'h3FFFFF));
        pending_reqs.push_back(make_req(OP_CHECK, 32'hFFFF_FFFF, {64{1'b1}}, {36{1'b1}},
                                        22'h3FFFFF));
        while (pending_reqs.size() > 0 || req_valid)
            @(posedge clk);

        run_phase(115, 22, 77);
        run_phase(115, 77, 22);
        run_phase(114, 0, 0);

        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d requests and %0d results, %0d with kill set.",
                 req_count, rsp_count, kill_count);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
